// ===== sv/assert_macros.svh =====
// Assertion helpers for the RTL files that check their own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle implication failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle implication failed");

`endif

// ===== sv/btb_pkg.sv =====
// ----------------------------------------------------------------------------
// btb_pkg
// Types and constants of the two-level branch predictor with target buffer.
// ----------------------------------------------------------------------------
package btb_pkg;

    localparam int unsigned ENT_BITS  = 5;
    localparam int unsigned HIST_BITS = 8;
    localparam int unsigned TAG_BITS  = 30;
    localparam int unsigned LC_BITS   = ENT_BITS + HIST_BITS;

    // Configuration register indexes.
    localparam logic [2:0] REG_INDEX_BITS  = 3'd0;
    localparam logic [2:0] REG_HIST_LEN    = 3'd1;
    localparam logic [2:0] REG_TAG_LEN     = 3'd2;
    localparam logic [2:0] REG_COUNTER_INIT = 3'd3;
    localparam logic [2:0] REG_GLOBAL_HIST = 3'd4;
    localparam logic [2:0] REG_GLOBAL_TABLE = 3'd5;
    localparam logic [2:0] REG_SHARE_MODE  = 3'd6;

    // Request operations.
    localparam logic OP_PREDICT = 1'b0;
    localparam logic OP_UPDATE  = 1'b1;

    // Sharing modes of the shared counter table.
    localparam logic [1:0] SHARE_NONE = 2'd0;
    localparam logic [1:0] SHARE_LOW  = 2'd1;
    localparam logic [1:0] SHARE_HIGH = 2'd2;

    typedef struct packed {
        logic        op;
        logic [31:0] pc;
        logic [31:0] target_pc;
        logic        was_taken;
        logic [31:0] predicted_dst;
    } req_t;

    typedef struct packed {
        logic        predict_taken;
        logic [31:0] predict_target;
        logic        flush;
        logic [31:0] branch_count;
        logic [31:0] flush_count;
    } rsp_t;

    typedef struct packed {
        logic [TAG_BITS-1:0]  tag;
        logic [31:0]          target;
        logic [HIST_BITS-1:0] lhist;
    } entry_t;

    // Counter memory read control.
    typedef struct packed {
        logic                 en;
        logic [LC_BITS-1:0]   laddr;
        logic [HIST_BITS-1:0] saddr;
    } ctr_rd_t;

    // Counter memory write control.
    typedef struct packed {
        logic                 lwe;
        logic [LC_BITS-1:0]   laddr;
        logic                 swe;
        logic [HIST_BITS-1:0] saddr;
        logic [1:0]           data;
    } ctr_wr_t;

endpackage

// ===== sv/btb_entry_mem.sv =====
// ----------------------------------------------------------------------------
// btb_entry_mem
// Per-entry storage of tag, target and local history, with a registered read.
// ----------------------------------------------------------------------------
module btb_entry_mem (
    input  logic                            clk,
    input  logic                            rd_en,
    input  logic [btb_pkg::ENT_BITS-1:0]    rd_addr,
    input  logic                            wr_en,
    input  logic [btb_pkg::ENT_BITS-1:0]    wr_addr,
    input  btb_pkg::entry_t                 wr_data,
    output btb_pkg::entry_t                 rd_data
);

    btb_pkg::entry_t mem [2**btb_pkg::ENT_BITS];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== sv/btb_ctr_mem.sv =====
// ----------------------------------------------------------------------------
// btb_ctr_mem
// Local and shared 2-bit counter tables, with registered reads.
// ----------------------------------------------------------------------------
module btb_ctr_mem (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             clr_shared,
    input  logic [1:0]       cinit,
    input  btb_pkg::ctr_rd_t rd,
    input  btb_pkg::ctr_wr_t wr,
    output logic [1:0]       lrd,
    output logic [1:0]       srd
);

    localparam int unsigned SDEPTH = 2**btb_pkg::HIST_BITS;

    logic [1:0]        lmem [2**btb_pkg::LC_BITS];
    logic [1:0]        smem [SDEPTH];
    logic [SDEPTH-1:0] svld_reg;
    logic              sv_q_reg;
    logic [1:0]        sd_q_reg;

    // Local table.
    always_ff @(posedge clk)
    begin
        if (wr.lwe)
        begin
            lmem[wr.laddr] <= wr.data;
        end
        if (rd.en)
        begin
            lrd <= lmem[rd.laddr];
        end
    end

    // Shared table.
    always_ff @(posedge clk)
    begin
        if (wr.swe)
        begin
            smem[wr.saddr] <= wr.data;
        end
        if (rd.en)
        begin
            sd_q_reg <= smem[rd.saddr];
        end
    end

    // Written marks of the shared table; an unmarked entry holds the initial value.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            svld_reg <= '0;
            sv_q_reg <= 1'b0;
        end
        else
        begin
            if (clr_shared)
            begin
                svld_reg <= '0;
            end
            else if (wr.swe)
            begin
                svld_reg[wr.saddr] <= 1'b1;
            end
            if (rd.en)
            begin
                sv_q_reg <= svld_reg[rd.saddr];
            end
        end
    end

    assign srd = sv_q_reg ? sd_q_reg : cinit;

endmodule

// ===== sv/btb_two_level_branch_predictor.sv =====
// ----------------------------------------------------------------------------
// btb_two_level_branch_predictor
// Direct-mapped target buffer with two-level direction prediction.
// ----------------------------------------------------------------------------
// Channel | Direction | Handshake          | Payload
// in      | input     | in_valid/in_stall  | in_req  (btb_pkg::req_t)
// out     | output    | out_valid/out_stall| out_rsp (btb_pkg::rsp_t)
// cfg     | input     | APB psel/penable   | paddr/pwdata/prdata
//
// A request runs through accept with entry memory read, counter memory
// read, then write-back and result. An update that allocates an entry first
// sweeps its 256 local counters to the initial value, then re-reads its counter.
// Reset clears control state, entry valid bits and shared-table marks.
// A stalled result waits in the output register; the next request is taken
// meanwhile, and its result waits at the end until the register frees.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module btb_two_level_branch_predictor (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_stall,
    input  btb_pkg::req_t   in_req,
    output logic            out_valid,
    input  logic            out_stall,
    output btb_pkg::rsp_t   out_rsp,
    input  logic            psel,
    input  logic            penable,
    input  logic            pwrite,
    input  logic [4:0]      paddr,
    input  logic [31:0]     pwdata,
    output logic [31:0]     prdata,
    output logic            pready
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_LOOK  = 3'd1;
    localparam logic [2:0] ST_SWEEP = 3'd2;
    localparam logic [2:0] ST_CRD   = 3'd3;
    localparam logic [2:0] ST_CNT   = 3'd4;
    localparam logic [2:0] ST_DONE  = 3'd5;

    // Configuration registers.
    logic [2:0] idx_bits_reg;
    logic [3:0] hist_len_reg;
    logic [4:0] tag_len_reg;
    logic [1:0] cinit_reg;
    logic       ghist_reg;
    logic       gtab_reg;
    logic [1:0] share_reg;

    logic [2:0]  state_reg, state_next;
    logic [7:0]  sweep_reg;
    btb_pkg::req_t req_reg;
    logic [btb_pkg::ENT_BITS-1:0] e_reg;
    logic [btb_pkg::TAG_BITS-1:0] tag_reg;
    logic        hit_reg;
    logic [31:0] tgt_reg;
    logic [7:0]  lh_reg;
    logic [7:0]  shist_reg;
    logic [7:0]  ci_s_reg;
    logic [btb_pkg::LC_BITS-1:0] ci_l_reg;
    logic [31:0] branch_reg;
    logic [31:0] flushes_reg;
    logic [31:0] entry_valid_reg;
    btb_pkg::rsp_t res_reg;
    logic        out_valid_reg;
    btb_pkg::rsp_t out_rsp_reg;

    logic        cfg_wr;
    logic        in_acc;
    logic        slot_free;
    logic [2:0]  eib;
    logic [4:0]  imask;
    logic [3:0]  ehl;
    logic [7:0]  hmask;
    logic [4:0]  etl;
    logic [btb_pkg::TAG_BITS-1:0] tmask;
    logic [btb_pkg::ENT_BITS-1:0] e_in;
    logic [btb_pkg::TAG_BITS-1:0] tag_in;
    btb_pkg::entry_t ent_rd;
    btb_pkg::entry_t ent_wr;
    logic        ent_we;
    logic        hit;
    logic        alloc;
    logic [7:0]  lh_src;
    logic [7:0]  h_rd;
    logic [7:0]  share_bits;
    btb_pkg::ctr_rd_t crd;
    btb_pkg::ctr_wr_t cwr;
    logic [1:0]  lrd;
    logic [1:0]  srd;
    logic [1:0]  cval;
    logic [1:0]  cnew;
    logic [7:0]  h_use;
    logic [7:0]  h_new;
    logic [31:0] pc4;
    logic [31:0] actual;
    logic        flush;
    logic [31:0] branch_new;
    logic [31:0] flushes_new;
    btb_pkg::rsp_t res_now;
    logic        upd;

    assign cfg_wr    = psel && penable && pwrite;
    assign pready    = 1'b1;
    assign in_stall  = (state_reg != ST_IDLE);
    assign in_acc    = in_valid && !in_stall;
    assign slot_free = !out_valid_reg || !out_stall;
    assign out_valid = out_valid_reg;
    assign out_rsp   = out_rsp_reg;

    // Effective field widths after clamping.
    always_comb
    begin
        eib   = (idx_bits_reg > 3'd5) ? 3'd5 : idx_bits_reg;
        imask = 5'((6'd1 << eib) - 6'd1);
        if (hist_len_reg == 4'd0)
        begin
            ehl = 4'd1;
        end
        else if (hist_len_reg > 4'd8)
        begin
            ehl = 4'd8;
        end
        else
        begin
            ehl = hist_len_reg;
        end
        hmask = 8'((9'd1 << ehl) - 9'd1);
        etl   = (tag_len_reg > 5'd30) ? 5'd30 : tag_len_reg;
        tmask = 30'((31'd1 << etl) - 31'd1);
        e_in   = in_req.pc[6:2] & imask;
        tag_in = (in_req.pc[31:2] >> eib) & tmask;
    end

    // Configuration write and read-back.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_bits_reg <= 3'd5;
            hist_len_reg <= 4'd8;
            tag_len_reg  <= 5'd30;
            cinit_reg    <= 2'd1;
            ghist_reg    <= 1'b0;
            gtab_reg     <= 1'b0;
            share_reg    <= btb_pkg::SHARE_NONE;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[4:2])
                btb_pkg::REG_INDEX_BITS:   idx_bits_reg <= pwdata[2:0];
                btb_pkg::REG_HIST_LEN:     hist_len_reg <= pwdata[3:0];
                btb_pkg::REG_TAG_LEN:      tag_len_reg  <= pwdata[4:0];
                btb_pkg::REG_COUNTER_INIT: cinit_reg    <= pwdata[1:0];
                btb_pkg::REG_GLOBAL_HIST:  ghist_reg    <= pwdata[0];
                btb_pkg::REG_GLOBAL_TABLE: gtab_reg     <= pwdata[0];
                btb_pkg::REG_SHARE_MODE:   share_reg    <= pwdata[1:0];
                default:                   ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[4:2])
            btb_pkg::REG_INDEX_BITS:   prdata = {29'd0, idx_bits_reg};
            btb_pkg::REG_HIST_LEN:     prdata = {28'd0, hist_len_reg};
            btb_pkg::REG_TAG_LEN:      prdata = {27'd0, tag_len_reg};
            btb_pkg::REG_COUNTER_INIT: prdata = {30'd0, cinit_reg};
            btb_pkg::REG_GLOBAL_HIST:  prdata = {31'd0, ghist_reg};
            btb_pkg::REG_GLOBAL_TABLE: prdata = {31'd0, gtab_reg};
            btb_pkg::REG_SHARE_MODE:   prdata = {30'd0, share_reg};
            default:                   prdata = 32'd0;
        endcase
    end

    // Entry lookup result.
    assign hit   = entry_valid_reg[e_reg] && (ent_rd.tag == tag_reg);
    assign alloc = (req_reg.op == btb_pkg::OP_UPDATE) && !hit;

    // Counter index for the read issued in the lookup or re-read state.
    always_comb
    begin
        lh_src = (state_reg == ST_LOOK) ? ent_rd.lhist : lh_reg;
        h_rd   = ghist_reg ? shist_reg : lh_src;
        priority case (share_reg)
            btb_pkg::SHARE_LOW:  share_bits = req_reg.pc[9:2];
            btb_pkg::SHARE_HIGH: share_bits = req_reg.pc[23:16];
            default:             share_bits = 8'd0;
        endcase
        crd.en    = ((state_reg == ST_LOOK) && !alloc) || (state_reg == ST_CRD);
        crd.saddr = (h_rd ^ share_bits) & hmask;
        crd.laddr = {e_reg, h_rd & hmask};
    end

    // Counter training, history shift, flush check and result.
    always_comb
    begin
        upd   = (req_reg.op == btb_pkg::OP_UPDATE);
        cval  = gtab_reg ? srd : lrd;
        if (req_reg.was_taken)
        begin
            cnew = (cval == 2'd3) ? cval : cval + 2'd1;
        end
        else
        begin
            cnew = (cval == 2'd0) ? cval : cval - 2'd1;
        end
        h_use  = ghist_reg ? shist_reg : lh_reg;
        h_new  = {h_use[6:0], req_reg.was_taken} & hmask;
        pc4    = req_reg.pc + 32'd4;
        actual = req_reg.was_taken ? req_reg.target_pc : pc4;
        flush  = upd && (req_reg.predicted_dst != actual);
        branch_new  = upd ? branch_reg + 32'd1 : branch_reg;
        flushes_new = flush ? flushes_reg + 32'd1 : flushes_reg;

        res_now.predict_taken  = !upd && hit_reg && cval[1];
        res_now.predict_target = upd ? 32'd0 : ((hit_reg && cval[1]) ? tgt_reg : pc4);
        res_now.flush          = flush;
        res_now.branch_count   = branch_new;
        res_now.flush_count    = flushes_new;

        cwr.lwe   = ((state_reg == ST_CNT) && upd && !gtab_reg) || (state_reg == ST_SWEEP);
        cwr.laddr = (state_reg == ST_SWEEP) ? {e_reg, sweep_reg} : ci_l_reg;
        cwr.swe   = (state_reg == ST_CNT) && upd && gtab_reg;
        cwr.saddr = ci_s_reg;
        cwr.data  = (state_reg == ST_SWEEP) ? cinit_reg : cnew;

        ent_we       = (state_reg == ST_CNT) && upd;
        ent_wr.tag   = tag_reg;
        ent_wr.target = req_reg.target_pc;
        ent_wr.lhist = ghist_reg ? lh_reg : h_new;
    end

    // Sequencer.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (in_acc) state_next = ST_LOOK;
            ST_LOOK:  state_next = alloc ? ST_SWEEP : ST_CNT;
            ST_SWEEP: if (sweep_reg == 8'hFF) state_next = ST_CRD;
            ST_CRD:   state_next = ST_CNT;
            ST_CNT:   state_next = slot_free ? ST_IDLE : ST_DONE;
            ST_DONE:  if (slot_free) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            sweep_reg       <= 8'd0;
            shist_reg       <= 8'd0;
            branch_reg      <= 32'd0;
            flushes_reg     <= 32'd0;
            entry_valid_reg <= 32'd0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_SWEEP)
            begin
                sweep_reg <= sweep_reg + 8'd1;
            end
            if (state_reg == ST_CNT)
            begin
                branch_reg  <= branch_new;
                flushes_reg <= flushes_new;
                if (upd)
                begin
                    entry_valid_reg[e_reg] <= 1'b1;
                    if (ghist_reg)
                    begin
                        shist_reg <= h_new;
                    end
                end
            end
            if (((state_reg == ST_CNT) || (state_reg == ST_DONE)) && slot_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Item and lookup payload.
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            req_reg <= in_req;
            e_reg   <= e_in;
            tag_reg <= tag_in;
        end
        if (state_reg == ST_LOOK)
        begin
            hit_reg <= hit;
            tgt_reg <= ent_rd.target;
            lh_reg  <= alloc ? 8'd0 : ent_rd.lhist;
        end
        if (crd.en)
        begin
            ci_s_reg <= crd.saddr;
            ci_l_reg <= crd.laddr;
        end
        if (state_reg == ST_CNT)
        begin
            res_reg <= res_now;
        end
        if ((state_reg == ST_CNT) && slot_free)
        begin
            out_rsp_reg <= res_now;
        end
        else if ((state_reg == ST_DONE) && slot_free)
        begin
            out_rsp_reg <= res_reg;
        end
    end

    btb_entry_mem u_entry (
        .clk     (clk),
        .rd_en   (in_acc),
        .rd_addr (e_in),
        .wr_en   (ent_we),
        .wr_addr (e_reg),
        .wr_data (ent_wr),
        .rd_data (ent_rd)
    );

    btb_ctr_mem u_ctr (
        .clk        (clk),
        .rst_n      (rst_n),
        .clr_shared (cfg_wr && (paddr[4:2] == btb_pkg::REG_COUNTER_INIT)),
        .cinit      (cinit_reg),
        .rd         (crd),
        .wr         (cwr),
        .lrd        (lrd),
        .srd        (srd)
    );

    // Checks.
    `ASSERT_NEXT(a_sweep_runs, (state_reg == ST_SWEEP) && (sweep_reg != 8'hFF), state_reg == ST_SWEEP)
    `ASSERT_IMPL(a_out_source, $rose(out_valid_reg), ($past(state_reg) == ST_CNT) || ($past(state_reg) == ST_DONE))
    `ASSERT_NEXT(a_update_valid, (state_reg == ST_CNT) && upd, entry_valid_reg[e_reg])

endmodule

// ===== tb/tb_btb_two_level_branch_predictor.sv =====
// ----------------------------------------------------------------------------
// tb_btb_two_level_branch_predictor
// Self-checking bench for the two-level branch predictor with target buffer.
// Predict and update requests are driven under random bursts and output
// stalls; each response is checked against a local model of the buffer,
// its histories and its counter tables, over several register settings.
// ----------------------------------------------------------------------------
module tb_btb_two_level_branch_predictor;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_ENT    = 32;
    localparam int CNT_PER    = 256;
    localparam int CYCLE_CAP  = 1500000;
    localparam int DRAIN_WAIT = 300;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    btb_pkg::req_t in_req;
    logic        out_valid;
    logic        out_stall;
    btb_pkg::rsp_t out_rsp;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    btb_two_level_branch_predictor dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_req(in_req),
        .out_valid(out_valid), .out_stall(out_stall), .out_rsp(out_rsp),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // Predictor copy of the registers and state.
    logic [2:0]  cfg_index_bits;
    logic [3:0]  cfg_hist_len;
    logic [4:0]  cfg_tag_len;
    logic [1:0]  cfg_counter_init;
    logic        cfg_global_hist;
    logic        cfg_global_table;
    logic [1:0]  cfg_share_mode;

    logic        ent_valid [NUM_ENT];
    logic [31:0] ent_tag [NUM_ENT];
    logic [31:0] ent_target [NUM_ENT];
    logic [7:0]  ent_hist [NUM_ENT];
    logic [1:0]  ent_ctr [NUM_ENT][CNT_PER];
    logic [1:0]  glob_ctr [CNT_PER];
    logic [7:0]  glob_hist;
    logic [31:0] update_total;
    logic [31:0] flush_total;

    btb_pkg::rsp_t expected_rsp_q[$];
    int          fail_count;
    longint      cycle_count;
    int          burst_left;
    int          gap_left;
    int          stall_mode;

    always #5 clk = ~clk;

    // Run limit.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_CAP)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // Receiver stall pattern: mode changes now and then.
    always @(posedge clk)
    begin
        if ($urandom_range(0, 199) == 0)
            stall_mode <= $urandom_range(0, 3);
        case (stall_mode)
            0: out_stall <= 1'b0;
            1: out_stall <= ($urandom_range(0, 3) == 0);
            2: out_stall <= ($urandom_range(0, 1) == 0);
            default: out_stall <= ($urandom_range(0, 9) < 8);
        endcase
    end

    // Response checker.
    always @(posedge clk)
    begin
        btb_pkg::rsp_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_rsp_q.size() == 0)
            begin
                $error("response with no request outstanding");
                fail_count++;
            end
            else
            begin
                want = expected_rsp_q.pop_front();
                if (out_rsp.predict_taken !== want.predict_taken)
                begin
                    $error("predict_taken: expected %0h actual %0h",
                           want.predict_taken, out_rsp.predict_taken);
                    fail_count++;
                end
                if (out_rsp.predict_target !== want.predict_target)
                begin
                    $error("predict_target: expected %0h actual %0h",
                           want.predict_target, out_rsp.predict_target);
                    fail_count++;
                end
                if (out_rsp.flush !== want.flush)
                begin
                    $error("flush: expected %0h actual %0h", want.flush, out_rsp.flush);
                    fail_count++;
                end
                if (out_rsp.branch_count !== want.branch_count)
                begin
                    $error("branch_count: expected %0h actual %0h",
                           want.branch_count, out_rsp.branch_count);
                    fail_count++;
                end
                if (out_rsp.flush_count !== want.flush_count)
                begin
                    $error("flush_count: expected %0h actual %0h",
                           want.flush_count, out_rsp.flush_count);
                    fail_count++;
                end
            end
        end
    end

    function automatic int eff_index_bits();
        return (cfg_index_bits > 5) ? 5 : int'(cfg_index_bits);
    endfunction

    function automatic logic [7:0] history_mask();
        int h;
        h = int'(cfg_hist_len);
        if (h < 1) h = 1;
        if (h > 8) h = 8;
        return 8'((9'd1 << h) - 1);
    endfunction

    // Counter index: position within the selected table; the shared table XORs in PC share bits.
    function automatic int counter_slot(int e, logic [31:0] pc);
        logic [7:0] h;
        logic [7:0] s;
        h = cfg_global_hist ? glob_hist : ent_hist[e];
        s = 8'd0;
        if (cfg_global_table)
        begin
            if (cfg_share_mode == btb_pkg::SHARE_LOW) s = pc[9:2];
            else if (cfg_share_mode == btb_pkg::SHARE_HIGH) s = pc[23:16];
            return int'((h ^ s) & history_mask());
        end
        return int'(h & history_mask());
    endfunction

    // Computes the response of one request and advances the model.
    function automatic btb_pkg::rsp_t predict_response(btb_pkg::req_t r);
        btb_pkg::rsp_t res;
        int          e;
        int          ib;
        int          tl;
        int          slot;
        logic [31:0] tag;
        logic [31:0] next_pc;
        logic [31:0] actual;
        logic [1:0]  c;
        logic        hit;
        ib = eff_index_bits();
        e = int'((r.pc >> 2) & ((32'd1 << ib) - 1));
        tl = (cfg_tag_len > 30) ? 30 : int'(cfg_tag_len);
        tag = ((r.pc >> 2) >> ib) & ((32'd1 << tl) - 1);
        hit = ent_valid[e] && (ent_tag[e] == tag);
        next_pc = r.pc + 32'd4;
        res = '0;
        if (r.op == btb_pkg::OP_PREDICT)
        begin
            res.predict_target = next_pc;
            if (hit)
            begin
                slot = counter_slot(e, r.pc);
                c = cfg_global_table ? glob_ctr[slot] : ent_ctr[e][slot];
                if (c >= 2)
                begin
                    res.predict_taken = 1'b1;
                    res.predict_target = ent_target[e];
                end
            end
        end
        else
        begin
            actual = r.was_taken ? r.target_pc : next_pc;
            if (!hit)
            begin
                ent_valid[e] = 1'b1;
                ent_tag[e] = tag;
                ent_hist[e] = 8'd0;
                for (int k = 0; k < CNT_PER; k++)
                    ent_ctr[e][k] = cfg_counter_init;
            end
            ent_target[e] = r.target_pc;
            slot = counter_slot(e, r.pc);
            c = cfg_global_table ? glob_ctr[slot] : ent_ctr[e][slot];
            if (r.was_taken && c < 3) c = c + 1;
            else if (!r.was_taken && c > 0) c = c - 1;
            if (cfg_global_table) glob_ctr[slot] = c;
            else ent_ctr[e][slot] = c;
            if (cfg_global_hist)
                glob_hist = ((glob_hist << 1) | r.was_taken) & history_mask();
            else
                ent_hist[e] = ((ent_hist[e] << 1) | r.was_taken) & history_mask();
            if (r.predicted_dst != actual)
            begin
                res.flush = 1'b1;
                flush_total++;
            end
            update_total++;
        end
        res.branch_count = update_total;
        res.flush_count = flush_total;
        return res;
    endfunction

    // Sends one request, with bursty gaps; valid drops only for a gap or a drain.
    task automatic send_request(btb_pkg::req_t r);
        if (burst_left == 0)
        begin
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            burst_left = $urandom_range(1, 12);
            if (gap_left > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap_left) @(posedge clk);
            end
        end
        burst_left--;
        in_valid <= 1'b1;
        in_req <= r;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        expected_rsp_q.push_back(predict_response(r));
    endtask

    task automatic drain();
        int guard;
        guard = 0;
        in_valid <= 1'b0;
        while (expected_rsp_q.size() != 0 && guard < 200000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    // Register write while idle; the caller ends the transfer.
    task automatic write_reg(logic [2:0] idx, logic [31:0] val);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        case (idx)
            btb_pkg::REG_INDEX_BITS:  cfg_index_bits = val[2:0];
            btb_pkg::REG_HIST_LEN:    cfg_hist_len = val[3:0];
            btb_pkg::REG_TAG_LEN:     cfg_tag_len = val[4:0];
            btb_pkg::REG_COUNTER_INIT:
            begin
                cfg_counter_init = val[1:0];
                for (int k = 0; k < CNT_PER; k++) glob_ctr[k] = val[1:0];
            end
            btb_pkg::REG_GLOBAL_HIST:  cfg_global_hist = val[0];
            btb_pkg::REG_GLOBAL_TABLE: cfg_global_table = val[0];
            btb_pkg::REG_SHARE_MODE:   cfg_share_mode = val[1:0];
            default: ;
        endcase
    endtask

    task automatic set_config(int ib, int hl, int tl, int ci, int gh, int gt, int sm);
        drain();
        write_reg(btb_pkg::REG_INDEX_BITS, ib);
        write_reg(btb_pkg::REG_HIST_LEN, hl);
        write_reg(btb_pkg::REG_TAG_LEN, tl);
        write_reg(btb_pkg::REG_COUNTER_INIT, ci);
        write_reg(btb_pkg::REG_GLOBAL_HIST, gh);
        write_reg(btb_pkg::REG_GLOBAL_TABLE, gt);
        write_reg(btb_pkg::REG_SHARE_MODE, sm);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    function automatic btb_pkg::req_t make_req(logic op, logic [31:0] pc, logic [31:0] tgt,
                                               logic tk, logic [31:0] pd);
        btb_pkg::req_t r;
        r.op = op;
        r.pc = pc;
        r.target_pc = tgt;
        r.was_taken = tk;
        r.predicted_dst = pd;
        return r;
    endfunction

    // Directed: field extremes, both operations, hit and miss, flush and no flush.
    task automatic test_directed();
        send_request(make_req(btb_pkg::OP_PREDICT, 32'h0000_0000, 32'h0, 1'b0, 32'h0));
        send_request(make_req(btb_pkg::OP_UPDATE, 32'h0000_0000, 32'hFFFF_FFFF, 1'b1,
                              32'hFFFF_FFFF));
        send_request(make_req(btb_pkg::OP_UPDATE, 32'h0000_0000, 32'hFFFF_FFFF, 1'b1,
                              32'h0000_0004));
        send_request(make_req(btb_pkg::OP_PREDICT, 32'h0000_0000, 32'h0, 1'b0, 32'h0));
        send_request(make_req(btb_pkg::OP_UPDATE, 32'hFFFF_FFFC, 32'h0000_0000, 1'b0,
                              32'h0000_0000));
        send_request(make_req(btb_pkg::OP_UPDATE, 32'hFFFF_FFFF, 32'h1234_5678, 1'b0,
                              32'h0000_0001));
        send_request(make_req(btb_pkg::OP_PREDICT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1,
                              32'hFFFF_FFFF));
        // Same index, different tag under the default settings: alias replaces the entry.
        send_request(make_req(btb_pkg::OP_UPDATE, 32'h8000_0000, 32'hAAAA_5555, 1'b1, 32'h0));
        send_request(make_req(btb_pkg::OP_UPDATE, 32'h8000_0000, 32'hAAAA_5555, 1'b1,
                              32'hAAAA_5555));
        send_request(make_req(btb_pkg::OP_PREDICT, 32'h8000_0000, 32'h0, 1'b0, 32'h0));
        send_request(make_req(btb_pkg::OP_PREDICT, 32'h0000_0000, 32'h0, 1'b0, 32'h0));
        send_request(make_req(btb_pkg::OP_UPDATE, 32'h5555_5554, 32'h5555_5555, 1'b1,
                              32'h5555_5555));
        send_request(make_req(btb_pkg::OP_PREDICT, 32'hAAAA_AAA8, 32'h0, 1'b0, 32'h0));
    endtask

    // Random: a small set of branch addresses, mostly reused, with updates and predictions mixed.
    task automatic test_random(int count);
        logic [31:0]   pcs[8];
        logic [31:0]   tgts[8];
        int            k;
        btb_pkg::req_t r;
        for (int i = 0; i < 8; i++)
        begin
            pcs[i] = $urandom();
            if ($urandom_range(0, 1)) pcs[i][31:7] = pcs[0][31:7];
            tgts[i] = $urandom();
        end
        for (int n = 0; n < count; n++)
        begin
            k = $urandom_range(0, 7);
            r.op = $urandom_range(0, 1);
            r.pc = ($urandom_range(0, 9) == 0) ? $urandom() : pcs[k];
            r.target_pc = ($urandom_range(0, 5) == 0) ? $urandom() : tgts[k];
            r.was_taken = ($urandom_range(0, 3) != 0);
            case ($urandom_range(0, 3))
                0: r.predicted_dst = r.pc + 32'd4;
                1: r.predicted_dst = $urandom();
                default: r.predicted_dst = r.target_pc;
            endcase
            send_request(r);
        end
    endtask

    initial
    begin
        clk = 1'b0;
        cycle_count = 0;
        fail_count = 0;
        burst_left = 0;
        stall_mode = 0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_req = '0;
        out_stall = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        cfg_index_bits = 3'd5;
        cfg_hist_len = 4'd8;
        cfg_tag_len = 5'd30;
        cfg_counter_init = 2'd1;
        cfg_global_hist = 1'b0;
        cfg_global_table = 1'b0;
        cfg_share_mode = btb_pkg::SHARE_NONE;
        glob_hist = '0;
        update_total = '0;
        flush_total = '0;
        for (int i = 0; i < NUM_ENT; i++)
        begin
            ent_valid[i] = 1'b0;
            ent_hist[i] = '0;
        end
        for (int k = 0; k < CNT_PER; k++) glob_ctr[k] = 2'd1;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random(200);
        set_config(0, 1, 0, 0, 1, 1, btb_pkg::SHARE_LOW);
        test_directed();
        test_random(150);
        set_config(5, 8, 30, 3, 1, 1, btb_pkg::SHARE_HIGH);
        test_random(150);
        set_config(2, 3, 4, 2, 0, 1, btb_pkg::SHARE_NONE);
        test_random(150);
        set_config(7, 15, 31, 1, 1, 0, 3);
        test_random(150);
        set_config(1, 0, 2, 0, 0, 0, btb_pkg::SHARE_LOW);
        test_random(150);
        set_config(3, 5, 7, 3, 0, 1, btb_pkg::SHARE_LOW);
        test_random(150);
        set_config(4, 2, 12, 2, 1, 1, 3);
        test_random(150);
        set_config(5, 8, 30, 1, 0, 0, btb_pkg::SHARE_NONE);
        test_random(150);
        drain();

        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
